FILE: src/ssr_pkg.sv
// Shared constants and types for the streaming substring replace block.
package ssr_pkg;

  localparam int MAX_PATTERN     = 8;
  localparam int MAX_REPLACEMENT = 8;
  localparam int HELD_DEPTH      = MAX_PATTERN - 1;
  localparam int LEN_W           = 4;
  localparam int HC_W            = 3;
  localparam int TOTAL_W         = 5;
  localparam int IDX_W           = 4;

  localparam logic [1:0] CFG_PATTERN_BYTES      = 2'd0;
  localparam logic [1:0] CFG_PATTERN_LENGTH     = 2'd1;
  localparam logic [1:0] CFG_REPLACEMENT_BYTES  = 2'd2;
  localparam logic [1:0] CFG_REPLACEMENT_LENGTH = 2'd3;

  typedef logic [MAX_PATTERN-1:0][7:0] run_t;

  typedef struct packed {
    run_t               run;
    logic [LEN_W-1:0]   pre_cnt;
    logic [LEN_W-1:0]   rep_cnt;
    logic [LEN_W-1:0]   tail_cnt;
    logic               marker;
    logic               last;
    logic               status;
    logic [TOTAL_W-1:0] total;
  } job_t;

endpackage

FILE: src/stream_substring_replace.sv
// Top level of the streaming substring replace block.
// Subject bytes enter one per cycle while in_stall_o is low. Each accepted byte
// is matched combinationally against the held window and its result words go
// to a result register that plays them out one word per cycle while the output
// is not stalled. An item that yields no word is not loaded; an item that yields
// k words (up to 15 when a replacement is expanded) holds the input until the
// result register plays its final word. Configuration writes are always ready.
module stream_substring_replace (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  subject_byte_i,
  input  logic        subject_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        byte_valid_o,
  output logic        out_last_o,
  output logic        status_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  logic [63:0]               pat_bytes_q, rep_bytes_q;
  logic [3:0]                pat_len_q, rep_len_q;
  logic [ssr_pkg::LEN_W-1:0] plen, rlen;
  logic                      take, emit_ready;
  ssr_pkg::job_t             job;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_bytes_q <= '0;
      pat_len_q   <= '0;
      rep_bytes_q <= '0;
      rep_len_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        ssr_pkg::CFG_PATTERN_BYTES:      pat_bytes_q <= cfg_data_i;
        ssr_pkg::CFG_PATTERN_LENGTH:     pat_len_q   <= cfg_data_i[3:0];
        ssr_pkg::CFG_REPLACEMENT_BYTES:  rep_bytes_q <= cfg_data_i;
        ssr_pkg::CFG_REPLACEMENT_LENGTH: rep_len_q   <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  assign plen = (pat_len_q > ssr_pkg::LEN_W'(ssr_pkg::MAX_PATTERN)) ?
                ssr_pkg::LEN_W'(ssr_pkg::MAX_PATTERN) : pat_len_q;
  assign rlen = (rep_len_q > ssr_pkg::LEN_W'(ssr_pkg::MAX_REPLACEMENT)) ?
                ssr_pkg::LEN_W'(ssr_pkg::MAX_REPLACEMENT) : rep_len_q;

  assign in_stall_o = !emit_ready;
  assign take       = in_valid_i && !in_stall_o;

  ssr_match u_match (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .byte_i (subject_byte_i),
    .last_i (subject_last_i),
    .pat_i  (pat_bytes_q),
    .plen_i (plen),
    .rlen_i (rlen),
    .job_o  (job)
  );

  ssr_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (take && (job.total != '0)),
    .job_i        (job),
    .rep_i        (rep_bytes_q),
    .ready_o      (emit_ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .byte_valid_o (byte_valid_o),
    .out_last_o   (out_last_o),
    .status_o     (status_o)
  );

endmodule

FILE: src/ssr_match.sv
// Held-byte window, prefix search and job build for one subject byte.
module ssr_match (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   take_i,
  input  logic [7:0]                             byte_i,
  input  logic                                   last_i,
  input  logic [ssr_pkg::MAX_PATTERN-1:0][7:0]   pat_i,
  input  logic [ssr_pkg::LEN_W-1:0]              plen_i,
  input  logic [ssr_pkg::LEN_W-1:0]              rlen_i,
  output ssr_pkg::job_t                          job_o
);

  logic [7:0]                      held_q [ssr_pkg::HELD_DEPTH];
  logic [7:0]                      held_d [ssr_pkg::HELD_DEPTH];
  logic [ssr_pkg::HC_W-1:0]        hc_q, hc_d;
  ssr_pkg::run_t                   run;
  logic [ssr_pkg::LEN_W-1:0]       n;
  logic [ssr_pkg::MAX_PATTERN-1:0] ok;
  logic [ssr_pkg::LEN_W-1:0]       s_sel;
  logic [ssr_pkg::LEN_W-1:0]       m;
  logic                            match;
  logic [ssr_pkg::LEN_W-1:0]       keep;

  always_comb begin
    for (int i = 0; i < ssr_pkg::HELD_DEPTH; i++) begin
      run[i] = (ssr_pkg::HC_W'(i) < hc_q) ? held_q[i] : byte_i;
    end
    run[ssr_pkg::MAX_PATTERN-1] = byte_i;
    n = {1'b0, hc_q} + ssr_pkg::LEN_W'(1);

    // candidate start s: run[s..n-1] must be a pattern prefix
    for (int s = 0; s < ssr_pkg::MAX_PATTERN; s++) begin
      ok[s] = (ssr_pkg::LEN_W'(s) < n) && ((n - ssr_pkg::LEN_W'(s)) <= plen_i);
      for (int j = 0; j < ssr_pkg::MAX_PATTERN; j++) begin
        if (s + j < ssr_pkg::MAX_PATTERN) begin
          if ((ssr_pkg::LEN_W'(j) < n - ssr_pkg::LEN_W'(s)) &&
              (run[s + j] != pat_i[j])) begin
            ok[s] = 1'b0;
          end
        end
      end
    end

    s_sel = n;
    for (int s = ssr_pkg::MAX_PATTERN - 1; s >= 0; s--) begin
      if (ok[s]) begin
        s_sel = ssr_pkg::LEN_W'(s);
      end
    end

    m     = n - s_sel;
    match = (m == plen_i);
    keep  = (last_i || match) ? '0 : m;

    for (int i = 0; i < ssr_pkg::HELD_DEPTH; i++) begin
      held_d[i] = run[ssr_pkg::HC_W'(s_sel + ssr_pkg::LEN_W'(i))];
    end

    job_o.run    = run;
    job_o.last   = last_i;
    if (plen_i == '0) begin
      job_o.pre_cnt  = '0;
      job_o.rep_cnt  = '0;
      job_o.tail_cnt = '0;
      job_o.marker   = last_i;
      job_o.status   = 1'b1;
      hc_d           = last_i ? '0 : hc_q;
    end else begin
      job_o.pre_cnt  = s_sel;
      job_o.rep_cnt  = match ? rlen_i : '0;
      job_o.tail_cnt = (last_i && !match) ? m : '0;
      job_o.marker   = last_i && (s_sel == '0) && (match ? (rlen_i == '0) : (m == '0));
      job_o.status   = 1'b0;
      hc_d           = keep[ssr_pkg::HC_W-1:0];
    end
    job_o.total = ssr_pkg::TOTAL_W'(job_o.pre_cnt) + ssr_pkg::TOTAL_W'(job_o.rep_cnt) +
                  ssr_pkg::TOTAL_W'(job_o.tail_cnt) + ssr_pkg::TOTAL_W'(job_o.marker);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hc_q <= '0;
    end else if (take_i) begin
      hc_q <= hc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i && (plen_i != '0)) begin
      for (int i = 0; i < ssr_pkg::HELD_DEPTH; i++) begin
        held_q[i] <= held_d[i];
      end
    end
  end

endmodule

FILE: src/ssr_emit.sv
// Result register that plays out one job as a sequence of output words.
module ssr_emit (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       load_i,
  input  ssr_pkg::job_t                              job_i,
  input  logic [ssr_pkg::MAX_REPLACEMENT-1:0][7:0]   rep_i,
  output logic                                       ready_o,
  output logic                                       out_valid_o,
  input  logic                                       out_stall_i,
  output logic [7:0]                                 out_byte_o,
  output logic                                       byte_valid_o,
  output logic                                       out_last_o,
  output logic                                       status_o
);

  ssr_pkg::job_t               job_q;
  logic                        busy_q;
  logic [ssr_pkg::IDX_W-1:0]   idx_q;
  logic [ssr_pkg::TOTAL_W-1:0] k;
  logic [ssr_pkg::TOTAL_W-1:0] b_pre, b_rep, b_tail;
  logic [ssr_pkg::TOTAL_W-1:0] r_off, t_off;
  logic                        final_w;

  always_comb begin
    k       = {1'b0, idx_q};
    b_pre   = ssr_pkg::TOTAL_W'(job_q.pre_cnt);
    b_rep   = b_pre + ssr_pkg::TOTAL_W'(job_q.rep_cnt);
    b_tail  = b_rep + ssr_pkg::TOTAL_W'(job_q.tail_cnt);
    r_off   = k - b_pre;
    t_off   = k - ssr_pkg::TOTAL_W'(job_q.rep_cnt);
    final_w = (k == job_q.total - ssr_pkg::TOTAL_W'(1));

    byte_valid_o = 1'b1;
    if (k < b_pre) begin
      out_byte_o = job_q.run[idx_q[2:0]];
    end else if (k < b_rep) begin
      out_byte_o = rep_i[r_off[2:0]];
    end else if (k < b_tail) begin
      out_byte_o = job_q.run[t_off[2:0]];
    end else begin
      out_byte_o   = 8'd0;
      byte_valid_o = 1'b0;
    end
    out_last_o  = job_q.last && final_w;
    status_o    = job_q.status;
    out_valid_o = busy_q;
    ready_o     = !busy_q || (final_w && !out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (load_i) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (busy_q && !out_stall_i) begin
      if (final_w) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q + ssr_pkg::IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      job_q <= job_i;
    end
  end

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> ({1'b0, idx_q} < job_q.total))
    else $error("word index past job length");

  a_marker_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !byte_valid_o) |-> out_last_o)
    else $error("bare marker without last");

  a_load_when_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> ready_o)
    else $error("job loaded while busy");

  a_drain_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && final_w && !out_stall_i && !load_i) |=> !busy_q)
    else $error("job not retired after final word");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the streaming substring replace block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY      = 20;
  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_ITEMS = 270;
  localparam int MAX_REPORTS  = 10;
  localparam int MAX_WORDS    = 2 * ssr_pkg::MAX_PATTERN + 2;

  localparam logic [3:0] WR_ALL     = 4'b1111;
  localparam logic [3:0] WR_PATTERN = (4'b1 << ssr_pkg::CFG_PATTERN_BYTES) |
                                      (4'b1 << ssr_pkg::CFG_PATTERN_LENGTH);

  typedef struct packed {
    logic [7:0] octet;
    logic       valid;
    logic       last;
    logic       status;
  } rewrite_word_t;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic [7:0]  subject_byte = 8'h00;
  logic        subject_last = 1'b0;
  logic        out_stall    = 1'b0;
  logic        cfg_valid    = 1'b0;
  logic [1:0]  cfg_index    = ssr_pkg::CFG_PATTERN_BYTES;
  logic [63:0] cfg_data     = 64'h0;

  logic        in_stall_o;
  logic        out_valid_o;
  logic [7:0]  out_byte_o;
  logic        byte_valid_o;
  logic        out_last_o;
  logic        status_o;
  logic        cfg_ready_o;

  // predictor state
  logic [63:0]                         pat_bytes_r = 64'h0;
  logic [ssr_pkg::LEN_W-1:0]           pat_len_r   = '0;
  logic [63:0]                         rep_bytes_r = 64'h0;
  logic [ssr_pkg::LEN_W-1:0]           rep_len_r   = '0;
  logic [ssr_pkg::HELD_DEPTH-1:0][7:0] held_r      = '0;
  int                                  held_cnt_r  = 0;

  rewrite_word_t pending_words[$];

  bit in_idle_en = 1'b1;
  bit stall_en   = 1'b1;

  int mismatches       = 0;
  int items_sent       = 0;
  int strings_sent     = 0;
  int words_checked    = 0;
  int settings_written = 0;
  int matches_replaced = 0;
  int empty_markers    = 0;
  int idle_cycles      = 0;

  stream_substring_replace uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .subject_byte_i (subject_byte),
    .subject_last_i (subject_last),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .out_byte_o     (out_byte_o),
    .byte_valid_o   (byte_valid_o),
    .out_last_o     (out_last_o),
    .status_o       (status_o),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always #2 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int pick_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic int clamp_len(input logic [ssr_pkg::LEN_W-1:0] v, input int cap);
    if (int'(v) > cap) return cap;
    return int'(v);
  endfunction

  function automatic bit is_pattern_prefix(input logic [ssr_pkg::MAX_PATTERN:0][7:0] win,
                                           input int start, input int len,
                                           input int plen);
    if (len > plen) return 1'b0;
    for (int i = 0; i < len; i++)
      if (win[start + i] != pat_bytes_r[8*i +: 8]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic predict_rewrite(input logic [7:0] b, input logic is_last);
    logic [ssr_pkg::MAX_PATTERN:0][7:0] win;
    rewrite_word_t outs [0:MAX_WORDS-1];
    int plen, rlen, n, s, m, k;
    plen = clamp_len(pat_len_r, ssr_pkg::MAX_PATTERN);
    rlen = clamp_len(rep_len_r, ssr_pkg::MAX_REPLACEMENT);
    k = 0;
    win = '0;
    if (plen == 0) begin
      // empty pattern: only the last byte answers, with a failing end marker
      if (is_last) begin
        held_cnt_r = 0;
        outs[0] = {8'h00, 1'b0, 1'b1, 1'b1};
        k = 1;
        empty_markers++;
      end
    end else begin
      n = (held_cnt_r > ssr_pkg::HELD_DEPTH) ? ssr_pkg::HELD_DEPTH : held_cnt_r;
      for (int i = 0; i < n; i++) win[i] = held_r[i];
      win[n] = b;
      n++;
      s = 0;
      while (s < n && !is_pattern_prefix(win, s, n - s, plen)) begin
        outs[k] = {win[s], 1'b1, 1'b0, 1'b0};
        k++;
        s++;
      end
      m = n - s;
      if (m == plen) begin
        for (int i = 0; i < rlen; i++) begin
          outs[k] = {rep_bytes_r[8*i +: 8], 1'b1, 1'b0, 1'b0};
          k++;
        end
        m = 0;
        matches_replaced++;
      end
      if (is_last) begin
        for (int i = 0; i < m; i++) begin
          outs[k] = {win[s + i], 1'b1, 1'b0, 1'b0};
          k++;
        end
        m = 0;
        if (k == 0) begin
          outs[0] = {8'h00, 1'b0, 1'b1, 1'b0};
          k = 1;
        end else begin
          outs[k - 1].last = 1'b1;
        end
      end
      for (int i = 0; i < m; i++) held_r[i] = win[s + i];
      held_cnt_r = m;
    end
    for (int i = 0; i < k; i++) pending_words.push_back(outs[i]);
  endtask

  task automatic send_word(input logic [7:0] b, input logic is_last);
    int gap;
    subject_byte <= b;
    subject_last <= is_last;
    in_valid     <= 1'b1;
    do @(posedge clk); while (in_stall_o);
    predict_rewrite(b, is_last);
    items_sent++;
    if (is_last) strings_sent++;
    gap = (in_idle_en && $urandom_range(0, 2) == 0) ? pick_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready_o);
    case (idx)
      ssr_pkg::CFG_PATTERN_BYTES:      pat_bytes_r = val;
      ssr_pkg::CFG_PATTERN_LENGTH:     pat_len_r   = val[ssr_pkg::LEN_W-1:0];
      ssr_pkg::CFG_REPLACEMENT_BYTES:  rep_bytes_r = val;
      ssr_pkg::CFG_REPLACEMENT_LENGTH: rep_len_r   = val[ssr_pkg::LEN_W-1:0];
      default: ;
    endcase
  endtask

  // block must be idle: drain results, then let a word still in flight finish
  task automatic program_regs(input logic [3:0] mask, input logic [63:0] pat,
                              input logic [ssr_pkg::LEN_W-1:0] plen, input logic [63:0] rep,
                              input logic [ssr_pkg::LEN_W-1:0] rlen);
    hold_until_drained();
    repeat (LATENCY) @(posedge clk);
    if (mask[ssr_pkg::CFG_PATTERN_BYTES])
      write_reg(ssr_pkg::CFG_PATTERN_BYTES, pat);
    if (mask[ssr_pkg::CFG_PATTERN_LENGTH])
      write_reg(ssr_pkg::CFG_PATTERN_LENGTH, 64'(plen));
    if (mask[ssr_pkg::CFG_REPLACEMENT_BYTES])
      write_reg(ssr_pkg::CFG_REPLACEMENT_BYTES, rep);
    if (mask[ssr_pkg::CFG_REPLACEMENT_LENGTH])
      write_reg(ssr_pkg::CFG_REPLACEMENT_LENGTH, 64'(rlen));
    cfg_valid <= 1'b0;
    settings_written++;
  endtask

  task automatic test_reset_defaults();
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b1);
  endtask

  task automatic test_match_and_shift();
    program_regs(WR_ALL, 64'h6261, 4'd2, 64'h5A5958, 4'd3);
    send_word(8'h61, 1'b0);
    send_word(8'h61, 1'b0);
    send_word(8'h62, 1'b0);
    send_word(8'h61, 1'b1);
  endtask

  task automatic test_delete_and_end_marker();
    program_regs(WR_ALL, 64'h0, 4'd1, '1, 4'd0);
    send_word(8'h00, 1'b1);
    send_word(8'hFF, 1'b0);
    send_word(8'h00, 1'b1);
  endtask

  task automatic test_longest_pattern();
    // oversized lengths saturate to eight
    program_regs(WR_ALL, '1, 4'hF, 64'h0123456789ABCDEF, 4'hC);
    for (int i = 0; i < ssr_pkg::MAX_PATTERN + 1; i++)
      send_word(8'hFF, i == ssr_pkg::MAX_PATTERN);
  endtask

  task automatic test_pattern_change_mid_string();
    program_regs(WR_ALL, 64'h636261, 4'd3, 64'h41, 4'd1);
    send_word(8'h61, 1'b0);
    send_word(8'h62, 1'b0);
    program_regs(WR_PATTERN, 64'h7978, 4'd2, 64'h0, 4'd0);
    send_word(8'h78, 1'b1);
  endtask

  task automatic test_random_streams();
    logic [7:0]       subj [0:31];
    logic [63:0]      pat, rep;
    logic [7:0]       c;
    logic [3:0]       mask;
    logic             tail;
    int phase, kind, plen, rlen, eplen, quota, sent, scored, len, n, piece, p, pos;
    bit cut;
    phase  = 0;
    scored = 0;
    while (scored < RANDOM_ITEMS) begin
      kind = phase % 6;
      pat  = {$urandom, $urandom};
      rep  = {$urandom, $urandom};
      plen = $urandom_range(1, ssr_pkg::MAX_PATTERN);
      rlen = $urandom_range(0, ssr_pkg::MAX_REPLACEMENT);
      case (kind)
        0: for (int i = 0; i < ssr_pkg::MAX_PATTERN; i++)
             pat[8*i +: 8] = ($urandom_range(0, 1) != 0) ? 8'h61 : 8'h62;
        1: begin
          plen = 1;
          rlen = 0;
        end
        2: begin
          plen = $urandom_range(ssr_pkg::MAX_PATTERN, 15);
          rlen = $urandom_range(ssr_pkg::MAX_REPLACEMENT, 15);
        end
        3: plen = 0;
        4: begin
          plen = $urandom_range(0, 15);
          rlen = $urandom_range(0, 15);
        end
        default: begin
          case ($urandom_range(0, 2))
            0: c = 8'h00;
            1: c = 8'hFF;
            default: c = 8'($urandom);
          endcase
          pat = {8{c}};
          rep = {8{~c}};
        end
      endcase
      mask = (phase == 0 || $urandom_range(0, 2) != 0) ? WR_ALL : WR_PATTERN;
      program_regs(mask, pat, ssr_pkg::LEN_W'(plen), rep, ssr_pkg::LEN_W'(rlen));
      eplen      = clamp_len(pat_len_r, ssr_pkg::MAX_PATTERN);
      in_idle_en = (phase != 1) && ($urandom_range(0, 3) != 0);
      stall_en   = (phase != 1) && ($urandom_range(0, 3) != 0);
      quota      = (eplen == 0) ? 8 : $urandom_range(25, 45);
      cut        = ($urandom_range(0, 2) == 0);
      sent       = 0;
      while (sent < quota) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 32) : $urandom_range(1, 16);
        n = 0;
        // mostly pattern pieces so matches and partial matches are common
        while (n < len) begin
          piece = $urandom_range(0, 9);
          if (eplen == 0 || piece < 2) begin
            subj[n] = 8'($urandom);
            n++;
          end else if (piece < 4) begin
            pos = $urandom_range(0, eplen - 1);
            subj[n] = pat_bytes_r[8*pos +: 8];
            n++;
          end else begin
            p = (piece < 7) ? eplen : $urandom_range(1, eplen);
            for (int j = 0; j < p && n < len; j++) begin
              subj[n] = pat_bytes_r[8*j +: 8];
              n++;
            end
          end
        end
        for (int i = 0; i < len; i++) begin
          tail = (i == len - 1) && !(cut && sent + len >= quota);
          send_word(subj[i], tail);
          if (eplen != 0 || tail) scored++;
        end
        sent += len;
        if ((phase == 0 && sent == len) || $urandom_range(0, 9) == 0) hold_until_drained();
      end
      phase++;
    end
  endtask

  initial begin : out_stall_gen
    bit stalling;
    int hold;
    stalling = 1'b0;
    hold     = 0;
    forever begin
      @(posedge clk);
      if (hold == 0) begin
        stalling = !stalling && stall_en && ($urandom_range(0, 2) == 0);
        hold     = stalling ? pick_len() : $urandom_range(1, 6);
      end
      hold--;
      out_stall <= stalling;
    end
  end

  always @(posedge clk) begin : check_word
    rewrite_word_t exp_w;
    if (rst_n && out_valid_o && !out_stall) begin
      words_checked++;
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%t unexpected word: byte %02h valid %b last %b status %b", $realtime,
                   out_byte_o, byte_valid_o, out_last_o, status_o);
      end else begin
        exp_w = pending_words.pop_front();
        if (out_byte_o !== exp_w.octet || byte_valid_o !== exp_w.valid ||
            out_last_o !== exp_w.last || status_o !== exp_w.status) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"%t mismatch: expected byte %02h valid %b last %b status %b,",
                      " got %02h %b %b %b"},
                     $realtime, exp_w.octet, exp_w.valid, exp_w.last, exp_w.status,
                     out_byte_o, byte_valid_o, out_last_o, status_o);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall) || (cfg_valid && cfg_ready_o))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout with %0d words outstanding", pending_words.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_match_and_shift();
    test_delete_and_end_marker();
    test_longest_pattern();
    test_pattern_change_mid_string();
    test_random_streams();
    hold_until_drained();
    repeat (LATENCY) @(posedge clk);
    if (pending_words.size() != 0) mismatches++;
    $display("Streamed %0d subject bytes in %0d strings over %0d register settings.",
             items_sent, strings_sent, settings_written);
    $display("Checked %0d output words: %0d matches replaced, %0d empty-pattern markers.",
             words_checked, matches_replaced, empty_markers);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: stream_substring_replace.f
src/ssr_pkg.sv
src/ssr_match.sv
src/ssr_emit.sv
src/stream_substring_replace.sv
tb/testbench.sv
